// ===== sv/ooks_pkg.sv =====
// ----------------------------------------------------------------------------
// ooks_pkg: shared types and constants
// Register indexes, widths and the structs passed between the pattern sender
// modules.
// ----------------------------------------------------------------------------
package ooks_pkg;

	localparam int ID_BITS_DEF = 16;

	localparam int IDENT_W    = 16;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int TICK_W     = 32;
	localparam int BIT_T_W    = 16;
	localparam int REP_W      = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_BIT_TIME  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_OFFSET    = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL  = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_REPEAT    = 2'd3;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	typedef struct packed {
		logic [BIT_T_W-1:0] bit_ticks;
		logic [TICK_W-1:0]  gap_ticks;
		logic [REP_W-1:0]   repeat_count;
	} timing_t;

	typedef struct packed {
		logic rejected;
		logic done_res;
		logic busy_res;
		logic pin_level;
	} result_t;

endpackage

// ===== sv/ooks_cfg.sv =====
// ----------------------------------------------------------------------------
// ooks_cfg: configuration registers
// Holds the four timing registers and registers the derived bit and gap
// durations so the per-item path sees only precomputed values.
// ----------------------------------------------------------------------------
module ooks_cfg #(
	parameter int ID_BITS = ooks_pkg::ID_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ooks_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [ooks_pkg::CFG_DATA_W-1:0]     cfg_data,
	output ooks_pkg::timing_t                   timing
);

	localparam int USED_W = ooks_pkg::TICK_W + 1;

	// gap derived from the register defaults
	localparam logic [ooks_pkg::TICK_W-1:0] GAP_RST = ooks_pkg::TICK_W'(10000 - 100 * ID_BITS);

	logic [ooks_pkg::BIT_T_W-1:0] bit_time_q;
	logic [7:0]                   offset_q;
	logic [ooks_pkg::TICK_W-1:0]  interval_q;
	logic [ooks_pkg::REP_W-1:0]   repeat_q;

	logic [USED_W-1:0]            used;
	logic [ooks_pkg::BIT_T_W-1:0] bit_ticks_d;
	logic [ooks_pkg::TICK_W-1:0]  gap_ticks_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_time_q <= 16'd100;
			offset_q   <= 8'd0;
			interval_q <= 32'd10000;
			repeat_q   <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				ooks_pkg::REG_BIT_TIME: bit_time_q <= cfg_data[ooks_pkg::BIT_T_W-1:0];
				ooks_pkg::REG_OFFSET:   offset_q   <= cfg_data[7:0];
				ooks_pkg::REG_INTERVAL: interval_q <= cfg_data[ooks_pkg::TICK_W-1:0];
				ooks_pkg::REG_REPEAT:   repeat_q   <= cfg_data[ooks_pkg::REP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		used = USED_W'(bit_time_q) * USED_W'(ID_BITS);
		if (bit_time_q > ooks_pkg::BIT_T_W'(offset_q))
			bit_ticks_d = bit_time_q - ooks_pkg::BIT_T_W'(offset_q);
		else
			bit_ticks_d = ooks_pkg::BIT_T_W'(1);
		if (USED_W'(interval_q) > used)
			gap_ticks_d = ooks_pkg::TICK_W'(USED_W'(interval_q) - used);
		else
			gap_ticks_d = '0;
	end

	// derived durations and repeat count, registered from the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing.bit_ticks    <= 16'd100;
			timing.gap_ticks    <= GAP_RST;
			timing.repeat_count <= 16'd1;
		end else begin
			timing.bit_ticks    <= bit_ticks_d;
			timing.gap_ticks    <= gap_ticks_d;
			timing.repeat_count <= repeat_q;
		end
	end

endmodule

// ===== sv/ooks_core.sv =====
// ----------------------------------------------------------------------------
// ooks_core: pattern sequencer
// Keeps the frame state and works out the result of one item in a single
// pass; state advances when the item is processed.
// ----------------------------------------------------------------------------
module ooks_core #(
	parameter int ID_BITS = ooks_pkg::ID_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             command,
	input  logic [ooks_pkg::IDENT_W-1:0]     ident,
	input  ooks_pkg::timing_t                timing,
	output ooks_pkg::result_t                res
);

	localparam int IDX_W = $clog2(ID_BITS + 1);

	logic [ID_BITS-1:0]           ident_q;
	logic [ID_BITS-1:0]           shift_q;
	logic [IDX_W-1:0]             index_q;
	logic [ooks_pkg::REP_W-1:0]   repeats_q;
	logic [ooks_pkg::TICK_W-1:0]  tick_q;
	logic                         gap_q;
	logic                         level_q;
	logic                         active_q;

	logic [ID_BITS-1:0]           ident_d;
	logic [ID_BITS-1:0]           shift_d;
	logic [IDX_W-1:0]             index_d;
	logic [ooks_pkg::REP_W-1:0]   repeats_d;
	logic [ooks_pkg::TICK_W-1:0]  tick_d;
	logic                         gap_d;
	logic                         level_d;
	logic                         active_d;

	logic [ID_BITS-1:0]           new_id;
	logic [ID_BITS-1:0]           shifted;
	logic [ooks_pkg::TICK_W-1:0]  tick_dec;
	logic [ooks_pkg::REP_W-1:0]   rep_dec;
	logic [IDX_W-1:0]             index_inc;

	always_comb begin
		new_id    = ident[ID_BITS-1:0];
		shifted   = shift_q << 1;
		tick_dec  = (tick_q != '0) ? tick_q - ooks_pkg::TICK_W'(1) : '0;
		rep_dec   = repeats_q - ooks_pkg::REP_W'(1);
		index_inc = index_q + IDX_W'(1);

		ident_d   = ident_q;
		shift_d   = shift_q;
		index_d   = index_q;
		repeats_d = repeats_q;
		tick_d    = tick_q;
		gap_d     = gap_q;
		level_d   = level_q;
		active_d  = active_q;
		res       = '0;

		if (command == ooks_pkg::CMD_START) begin
			if (active_q) begin
				res.rejected  = 1'b1;
				res.busy_res  = 1'b1;
				res.pin_level = level_q;
			end else if (timing.repeat_count != '0) begin
				ident_d   = new_id;
				shift_d   = new_id;
				repeats_d = timing.repeat_count;
				active_d  = 1'b1;
				index_d   = '0;
				gap_d     = 1'b0;
				level_d   = new_id[ID_BITS-1];
				tick_d    = ooks_pkg::TICK_W'(timing.bit_ticks);
				res.pin_level = new_id[ID_BITS-1];
				res.busy_res  = 1'b1;
			end
		end else if (active_q) begin
			res.pin_level = level_q;
			tick_d = tick_dec;
			if (tick_dec == '0) begin
				if (gap_q || (index_q == IDX_W'(ID_BITS) && timing.gap_ticks == '0)) begin
					// end of frame
					repeats_d = rep_dec;
					if (rep_dec == '0) begin
						active_d = 1'b0;
						gap_d    = 1'b0;
						level_d  = 1'b0;
						tick_d   = '0;
						index_d  = '0;
						res.done_res = 1'b1;
					end else begin
						index_d = '0;
						gap_d   = 1'b0;
						shift_d = ident_q;
						level_d = ident_q[ID_BITS-1];
						tick_d  = ooks_pkg::TICK_W'(timing.bit_ticks);
					end
				end else if (index_q != IDX_W'(ID_BITS)) begin
					index_d = index_inc;
					shift_d = shifted;
					level_d = (index_inc != IDX_W'(ID_BITS)) ? shifted[ID_BITS-1] : 1'b0;
					tick_d  = ooks_pkg::TICK_W'(timing.bit_ticks);
				end else begin
					gap_d   = 1'b1;
					level_d = 1'b0;
					tick_d  = timing.gap_ticks;
				end
			end
			res.busy_res = active_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ident_q   <= '0;
			shift_q   <= '0;
			index_q   <= '0;
			repeats_q <= '0;
			tick_q    <= '0;
			gap_q     <= 1'b0;
			level_q   <= 1'b0;
			active_q  <= 1'b0;
		end else if (adv) begin
			ident_q   <= ident_d;
			shift_q   <= shift_d;
			index_q   <= index_d;
			repeats_q <= repeats_d;
			tick_q    <= tick_d;
			gap_q     <= gap_d;
			level_q   <= level_d;
			active_q  <= active_d;
		end
	end

endmodule

// ===== sv/ook_id_pattern_sender.sv =====
// ----------------------------------------------------------------------------
// ook_id_pattern_sender: on-off keying identifier pattern timer
// Sends a loaded identifier MSB first, a trailing low bit and a low gap,
// repeated per start, timed by one-microsecond tick items.
// ----------------------------------------------------------------------------
// usage:
//  s_* channel carries one item per tick or start: s_tuser is the command
//  (0 tick, 1 start), s_tdata the identifier used on a start
//  m_* channel returns exactly one result item for each input item
//  cfg_we/cfg_addr/cfg_data write the timing registers while no item is in flight
//  path: input register, then the sequencer, then the result register
//  throughput: one item per cycle while results are taken, set by the state update
//  in the sequencer between the input register and the result register
//  reset: carrier off, idle, registers at their defaults (bit 100, offset 0,
//  interval 10000, repeat 1)
//  stall: while m_tready is low the result holds; one more item is taken
//  into the input register, then s_tready drops until the result is taken
// ----------------------------------------------------------------------------
module ook_id_pattern_sender #(
	parameter int ID_BITS = ooks_pkg::ID_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ooks_pkg::IDENT_W-1:0]     s_tdata,   // ident
	input  logic                             s_tuser,   // command
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,   // pin_level, busy_res, done_res, rejected, zeros
	input  logic                             cfg_we,
	input  logic [ooks_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [ooks_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic                          valid_s1;
	logic                          cmd_s1;
	logic [ooks_pkg::IDENT_W-1:0]  ident_s1;
	logic                          adv;
	ooks_pkg::timing_t             timing;
	ooks_pkg::result_t             res;

	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1   <= s_tuser;
			ident_s1 <= s_tdata;
		end
	end

	ooks_cfg #(
		.ID_BITS (ID_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.timing   (timing)
	);

	ooks_core #(
		.ID_BITS (ID_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.command (cmd_s1),
		.ident   (ident_s1),
		.timing  (timing),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {4'b0000, res.rejected, res.done_res, res.busy_res, res.pin_level};
		end
	end

endmodule
